// ----- sv/cps_pkg.sv -----
package cps_pkg;

	localparam int MAX_RESULTS = 8;
	localparam int RES_BITS = $clog2(MAX_RESULTS + 1);
	localparam int RES_IDX = $clog2(MAX_RESULTS);

	typedef enum logic [1:0] {
		MODE_ADD      = 2'd0,
		MODE_ADVANCE  = 2'd1,
		MODE_CLOSEOUT = 2'd2
	} mode_e;

	typedef enum logic [2:0] {
		KIND_PLACED   = 3'd0,
		KIND_QUEUED   = 3'd1,
		KIND_DROPPED  = 3'd2,
		KIND_RELEASED = 3'd3,
		KIND_CLOSEOUT = 3'd4,
		KIND_IDLE     = 3'd5
	} kind_e;

endpackage

// ----- sv/charger_pool_scheduler.sv -----
// Charger pool scheduler.
// Input channel (in_valid/in_stall) carries one request: mode, current_time,
// plane_id, charge_duration. Output channel (out_valid/out_stall) carries
// results: kind, out_plane_id, charged_time, next_event_time, last; last
// marks the final result of a request. Requests that give no result
// (advance releasing nothing, close-out with nothing charging, mode 3)
// simply end and the block takes the next request.
// The chargers are kept in a one-port-read slot memory sorted by finish
// time, earliest at the top of the used range; the waiting line is a
// second memory. One request is worked on at a time; in_stall is high
// while busy. A queued or dropped add goes straight to its result; a placed
// add is inserted from the top of the used range downward, shifting entries up
// (one read and one write per shifted slot). An advance releases finished planes, moves
// waiting planes into the chargers with the same insert, then gives one result per
// release. A close-out reports the charging planes one by one. If the receiver stalls, the
// block holds its output register and waits. Reset empties the chargers
// and the line and sets charger_count to 3; no memory clearing is needed.
// The user must write charger_count (cfg_we/cfg_wdata) only while idle; the block does not check.
module charger_pool_scheduler #(
	parameter int SLOTS = 8,
	parameter int WAIT_DEPTH = 16,
	parameter int TIME_BITS = 32,
	parameter int ID_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [3:0]           cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  cps_pkg::mode_e       mode,
	input  logic [TIME_BITS-1:0] current_time,
	input  logic [ID_BITS-1:0]   plane_id,
	input  logic [TIME_BITS-1:0] charge_duration,
	output logic                 out_valid,
	input  logic                 out_stall,
	output cps_pkg::kind_e       kind,
	output logic [ID_BITS-1:0]   out_plane_id,
	output logic [TIME_BITS-1:0] charged_time,
	output logic [TIME_BITS-1:0] next_event_time,
	output logic                 last
);
	import cps_pkg::*;

	localparam int SA = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int UW = $clog2(SLOTS + 1);
	localparam int WA = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int FW = $clog2(WAIT_DEPTH + 1);
	localparam int TW = FW + 1;
	localparam int CW = (UW > 4) ? ((UW > RES_BITS) ? UW : RES_BITS)
	                             : ((RES_BITS > 4) ? RES_BITS : 4);

	typedef struct packed {
		logic [TIME_BITS-1:0] fin;
		logic [TIME_BITS-1:0] start;
		logic [ID_BITS-1:0]   plane;
	} slot_t;

	typedef struct packed {
		logic [ID_BITS-1:0]   plane;
		logic [TIME_BITS-1:0] dur;
	} wait_t;

	typedef enum logic [13:0] {
		ST_IDLE    = 14'b00000000000001,
		ST_INS_RD  = 14'b00000000000010,
		ST_INS_CMP = 14'b00000000000100,
		ST_OUT1    = 14'b00000000001000,
		ST_REL_RD  = 14'b00000000010000,
		ST_REL_CHK = 14'b00000000100000,
		ST_MV      = 14'b00000001000000,
		ST_MV_WAIT = 14'b00000010000000,
		ST_EF_RD   = 14'b00000100000000,
		ST_EF_WAIT = 14'b00001000000000,
		ST_EMIT    = 14'b00010000000000,
		ST_CO_RD   = 14'b00100000000000,
		ST_CO_WAIT = 14'b01000000000000,
		ST_UNUSED  = 14'b10000000000000
	} state_t;

	function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
			input logic [TIME_BITS-1:0] b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
	endfunction

	state_t state_q;
	logic [3:0] cc_q;
	logic [UW-1:0] used_q;
	logic [WA-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic [TIME_BITS-1:0] earliest_q;
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] ins_fin_q;
	logic [TIME_BITS-1:0] ins_start_q;
	logic [ID_BITS-1:0] ins_plane_q;
	logic [UW-1:0] i_q;
	logic ret_mv_q;
	kind_e res_kind_q;
	logic [ID_BITS-1:0] res_plane_q;
	logic [RES_BITS-1:0] n_q;
	logic [RES_BITS-1:0] k_q;
	logic [ID_BITS-1:0] buf_plane_q [MAX_RESULTS];
	logic [TIME_BITS-1:0] buf_chg_q [MAX_RESULTS];

	logic out_valid_q;
	kind_e out_kind_q;
	logic [ID_BITS-1:0] out_plane_q;
	logic [TIME_BITS-1:0] out_chg_q;
	logic [TIME_BITS-1:0] out_next_q;
	logic out_last_q;

	slot_t s_mem [SLOTS];
	slot_t s_rd_q;
	logic s_rd_en, s_we;
	logic [SA-1:0] s_rd_addr, s_wa;
	slot_t s_wd;

	wait_t w_mem [WAIT_DEPTH];
	wait_t w_rd_q;
	logic w_rd_en, w_we;
	logic [WA-1:0] w_rd_addr, w_wa;
	wait_t w_wd;

	logic in_acc, out_free, ins_done, can_place, rel_more, co_last;
	logic [CW-1:0] cc_eff;
	logic [UW-1:0] used_m1, i_m1;
	logic [TW-1:0] tail_sum, tail;
	logic [RES_BITS-1:0] k_p1;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign cc_eff = (CW'(cc_q) > CW'(SLOTS)) ? CW'(SLOTS) : CW'(cc_q);
	assign can_place = CW'(used_q) < cc_eff;
	assign used_m1 = used_q - 1'b1;
	assign i_m1 = i_q - 1'b1;
	assign tail_sum = TW'(head_q) + TW'(fill_q);
	assign tail = (tail_sum >= TW'(WAIT_DEPTH)) ? tail_sum - TW'(WAIT_DEPTH) : tail_sum;
	assign rel_more = (used_q != '0) && (n_q < RES_BITS'(MAX_RESULTS));
	assign k_p1 = k_q + 1'b1;
	assign co_last = (CW'(k_p1) >= CW'(used_q)) || (k_p1 == RES_BITS'(MAX_RESULTS));
	assign ins_done = ((state_q == ST_INS_RD) && (i_q == '0)) ||
	                  ((state_q == ST_INS_CMP) && (s_rd_q.fin > ins_fin_q));

	always_comb begin
		s_rd_en = 1'b0;
		s_rd_addr = '0;
		s_we = 1'b0;
		s_wa = i_q[SA-1:0];
		s_wd = '{fin: ins_fin_q, start: ins_start_q, plane: ins_plane_q};
		w_rd_en = 1'b0;
		w_rd_addr = head_q;
		w_we = 1'b0;
		w_wa = tail[WA-1:0];
		w_wd = '{plane: plane_id, dur: charge_duration};
		unique case (state_q)
			ST_IDLE: begin
				w_we = in_acc && (mode == MODE_ADD) && !can_place &&
				       (fill_q < FW'(WAIT_DEPTH));
			end
			ST_INS_RD: begin
				if (i_q == '0) begin
					s_we = 1'b1;
				end else begin
					s_rd_en = 1'b1;
					s_rd_addr = i_m1[SA-1:0];
				end
			end
			ST_INS_CMP: begin
				// shift the entry up while it finishes no later than the new one
				s_we = 1'b1;
				if (s_rd_q.fin <= ins_fin_q) begin
					s_wd = s_rd_q;
				end
			end
			ST_REL_RD: begin
				s_rd_en = rel_more;
				s_rd_addr = used_m1[SA-1:0];
			end
			ST_MV: begin
				w_rd_en = (fill_q != '0) && can_place;
			end
			ST_EF_RD: begin
				s_rd_en = (used_q != '0);
				s_rd_addr = used_m1[SA-1:0];
			end
			ST_CO_RD: begin
				s_rd_en = 1'b1;
				s_rd_addr = k_q[SA-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_rd_en) begin
			s_rd_q <= s_mem[s_rd_addr];
		end
		if (s_we) begin
			s_mem[s_wa] <= s_wd;
		end
		if (w_rd_en) begin
			w_rd_q <= w_mem[w_rd_addr];
		end
		if (w_we) begin
			w_mem[w_wa] <= w_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cc_q <= 4'd3;
			used_q <= '0;
			head_q <= '0;
			fill_q <= '0;
			earliest_q <= '1;
			out_valid_q <= 1'b0;
			n_q <= '0;
			k_q <= '0;
			i_q <= '0;
			ret_mv_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cc_q <= cfg_wdata;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						now_q <= current_time;
						n_q <= '0;
						k_q <= '0;
						case (mode)
							MODE_ADD: begin
								res_plane_q <= plane_id;
								if (can_place) begin
									ins_fin_q <= sat_add(current_time, charge_duration);
									ins_start_q <= current_time;
									ins_plane_q <= plane_id;
									i_q <= used_q;
									ret_mv_q <= 1'b0;
									res_kind_q <= KIND_PLACED;
									state_q <= ST_INS_RD;
								end else if (fill_q < FW'(WAIT_DEPTH)) begin
									fill_q <= fill_q + 1'b1;
									res_kind_q <= KIND_QUEUED;
									state_q <= ST_OUT1;
								end else begin
									res_kind_q <= KIND_DROPPED;
									state_q <= ST_OUT1;
								end
							end
							MODE_ADVANCE: begin
								if (used_q == '0) begin
									res_kind_q <= KIND_IDLE;
									res_plane_q <= '0;
									state_q <= ST_OUT1;
								end else begin
									state_q <= ST_REL_RD;
								end
							end
							MODE_CLOSEOUT: begin
								if (used_q != '0) begin
									state_q <= ST_CO_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_INS_RD, ST_INS_CMP: begin
					if (ins_done) begin
						if (i_q == used_q) begin
							earliest_q <= ins_fin_q;
						end
						used_q <= used_q + 1'b1;
						state_q <= ret_mv_q ? ST_MV : ST_OUT1;
					end else if (state_q == ST_INS_RD) begin
						state_q <= ST_INS_CMP;
					end else begin
						i_q <= i_m1;
						state_q <= ST_INS_RD;
					end
				end
				ST_OUT1: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q <= res_kind_q;
						out_plane_q <= res_plane_q;
						out_chg_q <= '0;
						out_next_q <= earliest_q;
						out_last_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_REL_RD: begin
					state_q <= rel_more ? ST_REL_CHK : ST_MV;
				end
				ST_REL_CHK: begin
					if (s_rd_q.fin <= now_q) begin
						buf_plane_q[n_q[RES_IDX-1:0]] <= s_rd_q.plane;
						buf_chg_q[n_q[RES_IDX-1:0]] <= now_q - s_rd_q.start;
						n_q <= n_q + 1'b1;
						used_q <= used_m1;
						state_q <= ST_REL_RD;
					end else begin
						state_q <= ST_MV;
					end
				end
				ST_MV: begin
					state_q <= ((fill_q != '0) && can_place) ? ST_MV_WAIT : ST_EF_RD;
				end
				ST_MV_WAIT: begin
					ins_fin_q <= sat_add(now_q, w_rd_q.dur);
					ins_start_q <= now_q;
					ins_plane_q <= w_rd_q.plane;
					i_q <= used_q;
					ret_mv_q <= 1'b1;
					head_q <= (head_q == WA'(WAIT_DEPTH - 1)) ? '0 : head_q + 1'b1;
					fill_q <= fill_q - 1'b1;
					state_q <= ST_INS_RD;
				end
				ST_EF_RD: begin
					k_q <= '0;
					if (used_q == '0) begin
						earliest_q <= '1;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_EF_WAIT;
					end
				end
				ST_EF_WAIT: begin
					earliest_q <= s_rd_q.fin;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (n_q == '0) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q <= KIND_RELEASED;
						out_plane_q <= buf_plane_q[k_q[RES_IDX-1:0]];
						out_chg_q <= buf_chg_q[k_q[RES_IDX-1:0]];
						out_next_q <= earliest_q;
						out_last_q <= (k_p1 == n_q);
						k_q <= k_p1;
						if (k_p1 == n_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_CO_RD: begin
					state_q <= ST_CO_WAIT;
				end
				ST_CO_WAIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q <= KIND_CLOSEOUT;
						out_plane_q <= s_rd_q.plane;
						out_chg_q <= now_q - s_rd_q.start;
						out_next_q <= earliest_q;
						out_last_q <= co_last;
						k_q <= k_p1;
						state_q <= co_last ? ST_IDLE : ST_CO_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign kind = out_kind_q;
	assign out_plane_id = out_plane_q;
	assign charged_time = out_chg_q;
	assign next_event_time = out_next_q;
	assign last = out_last_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(used_q) <= CW'(SLOTS))
		else $error("charger use exceeds slot count");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(WAIT_DEPTH))
		else $error("waiting line overfilled");

	a_results_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= RES_BITS'(MAX_RESULTS))
		else $error("too many buffered releases");

	a_idle_earliest: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && used_q == '0) |-> (earliest_q == '1))
		else $error("earliest finish stale with no plane charging");

endmodule

// ----- sim/tb_charger_pool_scheduler.sv -----
module tb_charger_pool_scheduler;
	timeunit 1ns;
	timeprecision 1ps;
	import cps_pkg::*;

	localparam int NSLOT = 8;
	localparam int NWAIT = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE = 300;
	localparam logic [31:0] NO_FINISH = 32'hFFFF_FFFF;

	typedef struct packed {
		kind_e       k;
		logic [15:0] id;
		logic [31:0] charged;
		logic [31:0] next_fin;
		logic        lst;
	} report_t;

	typedef struct {
		logic [1:0]  m;
		logic [31:0] t;
		logic [15:0] id;
		logic [31:0] dur;
		bit          typed;
		report_t     rep;
	} row_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [3:0] cfg_wdata;
	logic in_valid, in_stall;
	mode_e mode;
	logic [31:0] current_time, charge_duration;
	logic [15:0] plane_id;
	logic out_valid, out_stall;
	kind_e kind;
	logic [15:0] out_plane_id;
	logic [31:0] charged_time, next_event_time;
	logic last;

	charger_pool_scheduler DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode),
		.current_time(current_time), .plane_id(plane_id),
		.charge_duration(charge_duration), .out_valid(out_valid),
		.out_stall(out_stall), .kind(kind), .out_plane_id(out_plane_id),
		.charged_time(charged_time), .next_event_time(next_event_time),
		.last(last)
	);

	// model of the pool
	logic [31:0] fin_at [NSLOT];
	logic [31:0] start_at [NSLOT];
	logic [15:0] slot_id [NSLOT];
	int used;
	logic [15:0] line_id [NWAIT];
	logic [31:0] line_dur [NWAIT];
	int line_head, line_fill;
	logic [31:0] earliest;
	logic [3:0] chargers;

	report_t pending [$];
	int errors, requests, results, cycles;
	bit calm;

	function automatic logic [31:0] finish_of(logic [31:0] now, logic [31:0] d);
		logic [32:0] s;
		s = {1'b0, now} + {1'b0, d};
		return s[32] ? NO_FINISH : s[31:0];
	endfunction

	function automatic void seat(logic [31:0] now, logic [15:0] id, logic [31:0] d);
		logic [31:0] f;
		int pos;
		f = finish_of(now, d);
		pos = 0;
		if (used >= NSLOT)
			return;
		while (pos < used && fin_at[pos] > f)
			pos++;
		for (int i = used; i > pos; i--) begin
			fin_at[i] = fin_at[i-1];
			start_at[i] = start_at[i-1];
			slot_id[i] = slot_id[i-1];
		end
		fin_at[pos] = f;
		start_at[pos] = now;
		slot_id[pos] = id;
		used++;
		earliest = fin_at[used-1];
	endfunction

	// work out the reports of one request and update the pool
	function automatic void schedule_request(logic [1:0] m, logic [31:0] now,
			logic [15:0] id, logic [31:0] d, bit keep);
		report_t r;
		report_t rel [$];
		int cap;
		kind_e kd;
		cap = (chargers > NSLOT) ? NSLOT : chargers;
		if (m == MODE_ADD) begin
			if (used < cap) begin
				seat(now, id, d);
				kd = KIND_PLACED;
			end else if (line_fill < NWAIT) begin
				line_id[(line_head + line_fill) % NWAIT] = id;
				line_dur[(line_head + line_fill) % NWAIT] = d;
				line_fill++;
				kd = KIND_QUEUED;
			end else
				kd = KIND_DROPPED;
			r = '{kd, id, 32'd0, earliest, 1'b1};
			if (keep) pending = {pending, r};
		end else if (m == MODE_ADVANCE) begin
			if (used == 0) begin
				r = '{KIND_IDLE, 16'd0, 32'd0, earliest, 1'b1};
				if (keep) pending = {pending, r};
				return;
			end
			while (used > 0 && rel.size() < MAX_RESULTS && fin_at[used-1] <= now) begin
				r = '{KIND_RELEASED, slot_id[used-1], now - start_at[used-1], 32'd0, 1'b0};
				rel = {rel, r};
				used--;
			end
			while (line_fill > 0 && used < cap) begin
				seat(now, line_id[line_head], line_dur[line_head]);
				line_head = (line_head + 1) % NWAIT;
				line_fill--;
			end
			earliest = used ? fin_at[used-1] : NO_FINISH;
			foreach (rel[i]) begin
				rel[i].next_fin = earliest;
				rel[i].lst = (i == rel.size() - 1);
				if (keep) pending = {pending, rel[i]};
			end
		end else if (m == MODE_CLOSEOUT) begin
			for (int i = 0; i < used && i < MAX_RESULTS; i++) begin
				r = '{KIND_CLOSEOUT, slot_id[i], now - start_at[i], earliest,
					1'(i == used - 1)};
				if (keep) pending = {pending, r};
			end
		end
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** charger_pool_scheduler: FAILED **");
			$finish;
		end
	end

	// receiver: stall in bursts
	initial begin
		int n;
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 10);
				out_stall <= 1;
				repeat (n) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	always @(posedge clk) begin
		report_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{kind, out_plane_id, charged_time, next_event_time, last};
			results++;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %p", $time, got);
			end else begin
				want = pending.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: mismatch expected %p actual %p", $time, want, got);
				end
			end
		end
	end

	task automatic send(logic [1:0] m, logic [31:0] t, logic [15:0] id,
			logic [31:0] d, bit typed, report_t rep);
		int n;
		if (!calm && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 10);
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1;
		mode <= mode_e'(m);
		current_time <= t;
		plane_id <= id;
		charge_duration <= d;
		do @(posedge clk); while (in_stall);
		requests++;
		schedule_request(m, t, id, d, !typed);
		if (typed) pending = {pending, rep};
	endtask

	task automatic set_chargers(logic [3:0] v);
		in_valid <= 0;
		while (pending.size() != 0) @(posedge clk);
		// hold for requests that end without a result
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		chargers = v;
		cfg_we <= 0;
	endtask

	row_t plan [] = '{
		'{MODE_ADVANCE, 32'd0, 16'd7, 32'd9, 1, '{KIND_IDLE, 16'd0, 32'd0, NO_FINISH, 1'b1}},
		'{MODE_CLOSEOUT, 32'd0, 16'd0, 32'd0, 0, '0},
		'{2'd3, 32'd5, 16'h1234, 32'd5, 0, '0},
		'{MODE_ADD, 32'd100, 16'd1, 32'd50, 1, '{KIND_PLACED, 16'd1, 32'd0, 32'd150, 1'b1}},
		'{MODE_ADD, 32'd100, 16'hFFFF, NO_FINISH, 1,
			'{KIND_PLACED, 16'hFFFF, 32'd0, 32'd150, 1'b1}},
		'{MODE_ADD, 32'hFFFF_FFF0, 16'd2, 32'd100, 0, '0},
		'{MODE_ADD, 32'd110, 16'd3, 32'd20, 1, '{KIND_QUEUED, 16'd3, 32'd0, 32'd150, 1'b1}},
		'{MODE_ADD, 32'd110, 16'd0, 32'd0, 1, '{KIND_QUEUED, 16'd0, 32'd0, 32'd150, 1'b1}},
		'{MODE_CLOSEOUT, 32'd200, 16'd0, 32'd0, 0, '0},
		'{MODE_ADVANCE, 32'd120, 16'd0, 32'd0, 0, '0},
		'{MODE_ADVANCE, 32'd150, 16'd0, 32'd0, 0, '0},
		'{MODE_ADVANCE, 32'd160, 16'd0, 32'd0, 0, '0},
		'{MODE_CLOSEOUT, 32'd50, 16'd0, 32'd0, 0, '0},
		'{MODE_ADVANCE, NO_FINISH, 16'd0, 32'd0, 0, '0},
		'{MODE_ADVANCE, NO_FINISH, 16'd0, 32'd0, 0, '0}
	};

	initial begin
		logic [3:0] counts [];
		logic [31:0] base, t, d;
		int pick;
		logic [1:0] m;
		counts = '{4'd0, 4'd8, 4'd15, 4'd1, 4'd5, 4'd8, 4'd2, 4'd3};
		errors = 0; requests = 0; results = 0; cycles = 0; calm = 0;
		used = 0; line_head = 0; line_fill = 0;
		earliest = NO_FINISH; chargers = 4'd3;
		cfg_we = 0; cfg_wdata = 0; in_valid = 0; mode = MODE_ADD;
		current_time = 0; plane_id = 0; charge_duration = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (plan[i])
			send(plan[i].m, plan[i].t, plan[i].id, plan[i].dur, plan[i].typed, plan[i].rep);

		base = 32'd1000;
		foreach (counts[p]) begin
			set_chargers(counts[p]);
			if (p == counts.size() - 2) calm = 1;
			for (int i = 0; i < 20; i++) begin
				pick = $urandom_range(0, 99);
				// count zero mostly fills the line so drops show up
				if (pick < ((counts[p] == 0) ? 80 : 52)) m = MODE_ADD;
				else if (pick < 92) m = MODE_ADVANCE;
				else if (pick < 98) m = MODE_CLOSEOUT;
				else m = 2'd3;
				base += $urandom_range(0, 30);
				t = ($urandom_range(0, 19) == 0) ? $urandom : base;
				d = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 60);
				send(m, t, 16'($urandom), d, 0, '0);
			end
		end
		in_valid <= 0;

		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("%0d requests over %0d charger settings, %0d results checked",
			requests, counts.size() + 1, results);
		if (errors == 0)
			$display("** charger_pool_scheduler: PASSED **");
		else
			$display("** charger_pool_scheduler: FAILED **");
		$finish;
	end
endmodule

// ----- charger_pool_scheduler.f -----
sv/cps_pkg.sv
sv/charger_pool_scheduler.sv
sim/tb_charger_pool_scheduler.sv
